// ===== design/irt_pkg.sv =====
// Shared constants, types and the digit character table for the radix text converter.
package irt_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 64;

    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W      = $clog2(MAX_DIGITS);

    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W       = DIV_STEPS * DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic [BASE_W-1:0] MIN_BASE   = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE   = BASE_W'(16);
    localparam logic [BASE_W-1:0] SIGN_BASE  = BASE_W'(10);
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [BASE_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } div_status_t;

endpackage

// ===== design/irt_stream_if.sv =====
// Valid/ready channel interfaces for input numbers and output characters.
interface irt_in_if;
    logic                            valid;
    logic                            ready;
    logic [irt_pkg::VALUE_WIDTH-1:0] value;
    logic                            is_signed;
    logic [irt_pkg::BASE_W-1:0]      base;

    modport source (output valid, output value, output is_signed, output base, input ready);
    modport sink   (input valid, input value, input is_signed, input base, output ready);
endinterface

interface irt_out_if;
    logic                       valid;
    logic                       ready;
    logic [irt_pkg::CHAR_W-1:0] char_code;
    logic                       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== design/irt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module irt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/irt_divider.sv =====
// Iterative divider by a small base, several quotient bits per cycle.
module irt_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  irt_pkg::div_req_t    req,
    output irt_pkg::div_status_t status
);

    logic [irt_pkg::DIV_W-1:0]   quo_reg;
    logic [irt_pkg::DIV_W-1:0]   quo_next;
    logic [irt_pkg::DIGIT_W-1:0] rem_reg;
    logic [irt_pkg::DIGIT_W-1:0] rem_next;
    logic [irt_pkg::BASE_W-1:0]  divisor_reg;
    logic [irt_pkg::STEP_W-1:0]  cnt_reg;
    logic [irt_pkg::STEP_W-1:0]  cnt_next;
    logic                        done_reg;
    logic                        done_next;
    logic [irt_pkg::BASE_W-1:0]  trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < irt_pkg::DIV_BITS; i++)
        begin
            trial    = {rem_next, quo_next[irt_pkg::DIV_W-1]};
            quo_next = {quo_next[irt_pkg::DIV_W-2:0], 1'b0};
            if (trial >= divisor_reg)
            begin
                rem_next    = irt_pkg::DIGIT_W'(trial - divisor_reg);
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[irt_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next = irt_pkg::STEP_W'(irt_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == irt_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= irt_pkg::DIV_W'(req.dividend);
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.done      = done_reg;
    assign status.quotient  = quo_reg[irt_pkg::VALUE_WIDTH-1:0];
    assign status.remainder = rem_reg;

endmodule

// ===== design/integer_to_radix_text.sv =====
// Top level: converts one integer into its ASCII text in a radix from 2 to 16.
// One number is taken at a time; din.ready is high only while the block is
// idle. Digits come least significant first from a shared divider that
// retires 8 quotient bits per cycle, and the digit store is then read back
// one character at a time (read, then present, held until dout.ready).
// Base 10 alone prefixes '-' on a negative signed value; bases outside 2..16
// are clamped; at most MAX_DIGITS low-order digits are kept.
module integer_to_radix_text (
    input logic            clk,
    input logic            rst_n,
    irt_in_if.sink         din,
    irt_out_if.source      dout
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_DIV  = 6'b000100,
        S_SIGN = 6'b001000,
        S_READ = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [irt_pkg::VALUE_WIDTH-1:0] value_reg;
    logic [irt_pkg::VALUE_WIDTH-1:0] value_next;
    logic [irt_pkg::BASE_W-1:0]      base_reg;
    logic [irt_pkg::BASE_W-1:0]      base_next;
    logic [irt_pkg::COUNT_W-1:0]     digit_count_reg;
    logic [irt_pkg::COUNT_W-1:0]     digit_count_next;
    logic                            sign_pending_reg;
    logic                            sign_pending_next;

    logic [irt_pkg::VALUE_WIDTH-1:0] in_value;
    logic [irt_pkg::BASE_W-1:0]      in_base;
    logic                            in_neg;
    logic [irt_pkg::COUNT_W-1:0]     rd_count;

    irt_pkg::div_req_t               div_req;
    irt_pkg::div_status_t            div_status;

    logic                            wr_en;
    logic                            rd_en;
    logic [irt_pkg::DIGIT_W-1:0]     rd_data;

    assign in_value = din.value[irt_pkg::VALUE_WIDTH-1:0];
    assign in_neg   = din.is_signed && in_value[irt_pkg::VALUE_WIDTH-1];
    assign in_base  = (din.base < irt_pkg::MIN_BASE) ? irt_pkg::MIN_BASE :
                      (din.base > irt_pkg::MAX_BASE) ? irt_pkg::MAX_BASE : din.base;
    assign rd_count = digit_count_reg - 1'b1;

    assign div_req.start    = (state_reg == S_LOAD);
    assign div_req.dividend = value_reg;
    assign div_req.divisor  = base_reg;

    assign wr_en = (state_reg == S_DIV) && div_status.done
                   && (digit_count_reg < irt_pkg::COUNT_W'(irt_pkg::MAX_DIGITS));
    assign rd_en = (state_reg == S_READ);

    irt_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .status (div_status)
    );

    irt_ram #(
        .WIDTH (irt_pkg::DIGIT_W),
        .DEPTH (irt_pkg::MAX_DIGITS)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (digit_count_reg[irt_pkg::ADDR_W-1:0]),
        .wr_data (div_status.remainder),
        .rd_en   (rd_en),
        .rd_addr (rd_count[irt_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        value_next        = value_reg;
        base_next         = base_reg;
        digit_count_next  = digit_count_reg;
        sign_pending_next = sign_pending_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (din.valid)
                begin
                    value_next        = in_neg ? (~in_value + 1'b1) : in_value;
                    base_next         = in_base;
                    sign_pending_next = in_neg && (in_base == irt_pkg::SIGN_BASE);
                    digit_count_next  = '0;
                    state_next        = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    value_next = div_status.quotient;
                    if (wr_en)
                    begin
                        digit_count_next = digit_count_reg + 1'b1;
                    end
                    if (div_status.quotient != '0)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (sign_pending_reg)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_SIGN:
            begin
                if (dout.ready)
                begin
                    sign_pending_next = 1'b0;
                    state_next        = S_READ;
                end
            end
            S_READ:
            begin
                digit_count_next = rd_count;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (dout.ready)
                begin
                    state_next = (digit_count_reg == '0) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            digit_count_reg  <= '0;
            sign_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            digit_count_reg  <= digit_count_next;
            sign_pending_reg <= sign_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        base_reg  <= base_next;
    end

    assign din.ready      = (state_reg == S_IDLE);
    assign dout.valid     = (state_reg == S_SIGN) || (state_reg == S_EMIT);
    assign dout.char_code = (state_reg == S_SIGN) ? irt_pkg::MINUS_CHAR
                                                  : irt_pkg::DIGIT_CHARS[rd_data];
    assign dout.last      = (state_reg == S_EMIT) && (digit_count_reg == '0);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        din.ready |-> !dout.valid)
        else $error("input taken while a character is pending");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= irt_pkg::COUNT_W'(irt_pkg::MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && dout.last) |=> din.ready)
        else $error("block not idle after final character");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIGN) |-> (digit_count_reg != '0))
        else $error("minus sign with no digits behind it");

endmodule
